// ===== rtl/epoch_seconds_to_utc_calendar_macros.svh =====
// Assertion macros for the epoch seconds to UTC calendar converter.
`ifndef EPOCH_SECONDS_TO_UTC_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_UTC_CALENDAR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ESUC_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`define ESUC_ASSERT_NXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define ESUC_ASSERT_IMP(label, pre, post, msg)

`define ESUC_ASSERT_NXT(label, pre, post, msg)

`endif

`endif

// ===== rtl/esuc_pkg.sv =====
// Types, microcode codes, constants and calendar functions of the UTC calendar converter.
package esuc_pkg;

	typedef logic [3:0] step_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_DIV,
		OP_TOD,
		OP_HOUR,
		OP_MIN,
		OP_WDAY,
		OP_YEAR,
		OP_MON_INIT,
		OP_MON,
		OP_FINISH
	} op_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_WAIT_IN,
		COND_YEAR,
		COND_MON,
		COND_WAIT_OUT
	} cond_t;

	typedef enum logic [1:0] {
		DIV_DAY,
		DIV_HOUR,
		DIV_MIN,
		DIV_WEEK
	} divsel_t;

	typedef struct packed {
		op_t     op;
		cond_t   cond;
		divsel_t dsel;
		step_t   next;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic year_fits;
		logic mon_adv;
		logic out_free;
	} flags_t;

	localparam step_t ST_IDLE     = 4'd0;
	localparam step_t ST_DIV_DAY  = 4'd1;
	localparam step_t ST_TOD      = 4'd2;
	localparam step_t ST_DIV_HOUR = 4'd3;
	localparam step_t ST_HOUR     = 4'd4;
	localparam step_t ST_DIV_MIN  = 4'd5;
	localparam step_t ST_MIN      = 4'd6;
	localparam step_t ST_DIV_WEEK = 4'd7;
	localparam step_t ST_WDAY     = 4'd8;
	localparam step_t ST_YEAR     = 4'd9;
	localparam step_t ST_MON_INIT = 4'd10;
	localparam step_t ST_MON      = 4'd11;
	localparam step_t ST_FINISH   = 4'd12;

	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN  = 17'd60;
	localparam logic [16:0] DAYS_PER_WEEK = 17'd7;

	// Rounded-up reciprocals: 86400 = 675 << 7, 3600 = 225 << 4, 60 = 15 << 2.
	localparam logic [25:0] RECIP_DAY  = 26'd50903317; // 2^35 / 675
	localparam logic [25:0] RECIP_HOUR = 26'd9321;     // 2^21 / 225
	localparam logic [25:0] RECIP_MIN  = 26'd1093;     // 2^14 / 15
	localparam logic [25:0] RECIP_WEEK = 26'd74899;    // 2^19 / 7

	localparam logic [7:0]  YEAR_BASE    = 8'd70;
	localparam logic [7:0]  YEAR_2100    = 8'd200;
	localparam logic [16:0] WEEKDAY_1970 = 17'd4;
	localparam logic [3:0]  LAST_MONTH   = 4'd11;

	function automatic logic [16:0] divisor(input divsel_t sel);
		logic [16:0] d;
		case (sel)
			DIV_DAY:  d = SECS_PER_DAY;
			DIV_HOUR: d = SECS_PER_HOUR;
			DIV_MIN:  d = SECS_PER_MIN;
			default:  d = DAYS_PER_WEEK;
		endcase
		return d;
	endfunction

	// Years 1970 to 2106: every fourth year leaps, except 2100.
	function automatic logic is_leap(input logic [7:0] yr);
		return (yr[1:0] == 2'b00) && (yr != YEAR_2100);
	endfunction

	function automatic logic [8:0] year_len(input logic [7:0] yr);
		return is_leap(yr) ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] s;
		case (m)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd59;
			4'd3:    s = 9'd90;
			4'd4:    s = 9'd120;
			4'd5:    s = 9'd151;
			4'd6:    s = 9'd181;
			4'd7:    s = 9'd212;
			4'd8:    s = 9'd243;
			4'd9:    s = 9'd273;
			4'd10:   s = 9'd304;
			4'd11:   s = 9'd334;
			default: s = 9'd365;
		endcase
		if (leap && (m >= 4'd2)) begin
			s = s + 9'd1;
		end
		return s;
	endfunction

endpackage

// ===== rtl/esuc_urom.sv =====
// Microcode table of the UTC calendar converter: one control word per step.
module esuc_urom (
	input  esuc_pkg::step_t upc,
	output esuc_pkg::ctl_t  ctl
);
	import esuc_pkg::*;

	always_comb begin
		unique case (upc)
			ST_IDLE:     ctl = '{OP_IDLE,     COND_WAIT_IN,  DIV_DAY,  ST_DIV_DAY};
			ST_DIV_DAY:  ctl = '{OP_DIV,      COND_NONE,     DIV_DAY,  ST_TOD};
			ST_TOD:      ctl = '{OP_TOD,      COND_NONE,     DIV_DAY,  ST_DIV_HOUR};
			ST_DIV_HOUR: ctl = '{OP_DIV,      COND_NONE,     DIV_HOUR, ST_HOUR};
			ST_HOUR:     ctl = '{OP_HOUR,     COND_NONE,     DIV_HOUR, ST_DIV_MIN};
			ST_DIV_MIN:  ctl = '{OP_DIV,      COND_NONE,     DIV_MIN,  ST_MIN};
			ST_MIN:      ctl = '{OP_MIN,      COND_NONE,     DIV_MIN,  ST_DIV_WEEK};
			ST_DIV_WEEK: ctl = '{OP_DIV,      COND_NONE,     DIV_WEEK, ST_WDAY};
			ST_WDAY:     ctl = '{OP_WDAY,     COND_NONE,     DIV_WEEK, ST_YEAR};
			ST_YEAR:     ctl = '{OP_YEAR,     COND_YEAR,     DIV_DAY,  ST_MON_INIT};
			ST_MON_INIT: ctl = '{OP_MON_INIT, COND_NONE,     DIV_DAY,  ST_MON};
			ST_MON:      ctl = '{OP_MON,      COND_MON,      DIV_DAY,  ST_FINISH};
			ST_FINISH:   ctl = '{OP_FINISH,   COND_WAIT_OUT, DIV_DAY,  ST_IDLE};
			default:     ctl = '{OP_IDLE,     COND_WAIT_IN,  DIV_DAY,  ST_DIV_DAY};
		endcase
	end

endmodule

// ===== rtl/esuc_seq.sv =====
// Step counter of the UTC calendar converter with conditional hold and jump.
module esuc_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  esuc_pkg::ctl_t   ctl,
	input  esuc_pkg::flags_t flags,
	output esuc_pkg::step_t  upc
);
	import esuc_pkg::*;

	step_t upc_q;
	logic  hold;

	always_comb begin
		unique case (ctl.cond)
			COND_NONE:     hold = 1'b0;
			COND_WAIT_IN:  hold = !flags.in_valid;
			COND_YEAR:     hold = flags.year_fits;
			COND_MON:      hold = flags.mon_adv;
			COND_WAIT_OUT: hold = !flags.out_free;
			default:       hold = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_IDLE;
		end else if (!hold) begin
			upc_q <= ctl.next;
		end
	end

	assign upc = upc_q;

endmodule

// ===== rtl/esuc_dp.sv =====
// Datapath of the UTC calendar converter: reciprocal divider, year and month steps, output register.
module esuc_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  esuc_pkg::ctl_t   ctl,
	output esuc_pkg::flags_t flags,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [31:0]      epoch_seconds,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [5:0]       second,
	output logic [5:0]       minute,
	output logic [4:0]       hour,
	output logic [4:0]       month_day,
	output logic [3:0]       month,
	output logic [7:0]       years_since_1900,
	output logic [2:0]       weekday,
	output logic [8:0]       year_day
);
	import esuc_pkg::*;

	logic [31:0] r_q;
	logic [15:0] q_q;
	logic [15:0] days_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [2:0]  wday_q;
	logic [7:0]  year_q;
	logic [8:0]  yday_q;
	logic [3:0]  month_q;

	logic        out_valid_q;
	logic [5:0]  second_q;
	logic [5:0]  minute_q;
	logic [4:0]  hour_out_q;
	logic [4:0]  month_day_q;
	logic [3:0]  month_out_q;
	logic [7:0]  year_out_q;
	logic [2:0]  weekday_q;
	logic [8:0]  year_day_q;

	logic [24:0] mul_a;
	logic [25:0] mul_b;
	logic [50:0] mul_p;
	logic [15:0] quot;
	logic [32:0] rem_p;
	logic [31:0] rem;
	logic [16:0] wsum;
	logic [8:0]  ylen;
	logic        leap;
	logic [8:0]  mday_full;
	logic        year_fits;
	logic        mon_adv;
	logic        out_free;
	logic        accept;
	logic        fin;

	always_comb begin
		case (ctl.dsel)
			DIV_DAY: begin
				mul_a = r_q[31:7];
				mul_b = RECIP_DAY;
			end
			DIV_HOUR: begin
				mul_a = {12'd0, r_q[16:4]};
				mul_b = RECIP_HOUR;
			end
			DIV_MIN: begin
				mul_a = {15'd0, r_q[11:2]};
				mul_b = RECIP_MIN;
			end
			default: begin
				mul_a = {9'd0, r_q[15:0]};
				mul_b = RECIP_WEEK;
			end
		endcase
	end

	assign mul_p = {26'd0, mul_a} * {25'd0, mul_b};

	always_comb begin
		case (ctl.dsel)
			DIV_DAY:  quot = mul_p[50:35];
			DIV_HOUR: quot = {11'd0, mul_p[25:21]};
			DIV_MIN:  quot = {10'd0, mul_p[19:14]};
			default:  quot = mul_p[34:19];
		endcase
	end

	assign rem_p = {17'd0, q_q} * {16'd0, divisor(ctl.dsel)};
	assign rem   = r_q - rem_p[31:0];

	assign wsum      = {1'b0, days_q} + WEEKDAY_1970;
	assign ylen      = year_len(year_q);
	assign leap      = is_leap(year_q);
	assign year_fits = days_q >= {7'd0, ylen};
	assign mon_adv   = (month_q < LAST_MONTH) &&
	                   (yday_q >= month_start(month_q + 4'd1, leap));
	assign mday_full = yday_q - month_start(month_q, leap) + 9'd1;

	assign in_ready = ctl.op == OP_IDLE;
	assign accept   = in_ready && in_valid;
	assign out_free = !out_valid_q || out_ready;
	assign fin      = (ctl.op == OP_FINISH) && out_free;

	assign flags = '{in_valid, year_fits, mon_adv, out_free};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_IDLE: if (accept) begin
				r_q <= epoch_seconds;
			end
			OP_DIV: begin
				q_q <= quot;
			end
			OP_TOD: begin
				days_q <= q_q;
				r_q    <= rem;
			end
			OP_HOUR: begin
				hour_q <= q_q[4:0];
				r_q    <= rem;
			end
			OP_MIN: begin
				min_q <= q_q[5:0];
				sec_q <= rem[5:0];
				r_q   <= {15'd0, wsum};
			end
			OP_WDAY: begin
				wday_q <= rem[2:0];
				year_q <= YEAR_BASE;
			end
			OP_YEAR: if (year_fits) begin
				days_q <= days_q - {7'd0, ylen};
				year_q <= year_q + 8'd1;
			end
			OP_MON_INIT: begin
				yday_q  <= days_q[8:0];
				month_q <= '0;
			end
			OP_MON: if (mon_adv) begin
				month_q <= month_q + 4'd1;
			end
			OP_FINISH: if (out_free) begin
				second_q    <= sec_q;
				minute_q    <= min_q;
				hour_out_q  <= hour_q;
				month_day_q <= mday_full[4:0];
				month_out_q <= month_q;
				year_out_q  <= year_q;
				weekday_q   <= wday_q;
				year_day_q  <= yday_q;
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign second           = second_q;
	assign minute           = minute_q;
	assign hour             = hour_out_q;
	assign month_day        = month_day_q;
	assign month            = month_out_q;
	assign years_since_1900 = year_out_q;
	assign weekday          = weekday_q;
	assign year_day         = year_day_q;

endmodule

// ===== rtl/epoch_seconds_to_utc_calendar.sv =====
// Top level of the converter from 32-bit epoch seconds to the broken-down UTC calendar.
// The year step loops once per whole year after 1970 (0..136) and the month step once per
// month index (0..11). One item is in flight at a time, run by the single microcoded datapath:
// four reciprocal-multiply divides, one year per cycle, one month per cycle; a new item is
// accepted only back at idle, and the finish step holds while the output is not free.
// Reset: arst_n clears the step counter and the output valid; the block then waits idle.
`include "epoch_seconds_to_utc_calendar_macros.svh"

module epoch_seconds_to_utc_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  second,
	output logic [5:0]  minute,
	output logic [4:0]  hour,
	output logic [4:0]  month_day,
	output logic [3:0]  month,
	output logic [7:0]  years_since_1900,
	output logic [2:0]  weekday,
	output logic [8:0]  year_day
);
	import esuc_pkg::*;

	step_t  upc;
	ctl_t   ctl;
	flags_t flags;

	esuc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.flags  (flags),
		.upc    (upc)
	);

	esuc_urom u_urom (
		.upc (upc),
		.ctl (ctl)
	);

	esuc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.flags            (flags),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.epoch_seconds    (epoch_seconds),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.second           (second),
		.minute           (minute),
		.hour             (hour),
		.month_day        (month_day),
		.month            (month),
		.years_since_1900 (years_since_1900),
		.weekday          (weekday),
		.year_day         (year_day)
	);

	`ESUC_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, !in_ready, "accepted item did not start the program")
	`ESUC_ASSERT_NXT(a_finish_publishes, (ctl.op == OP_FINISH) && flags.out_free, out_valid && in_ready, "finished item not published or program not back at idle")
	`ESUC_ASSERT_NXT(a_year_exit, (ctl.op == OP_YEAR) && !flags.year_fits, ctl.op == OP_MON_INIT, "year loop did not exit to the month search")

endmodule
